/* sv/jsu_pkg.sv */
// types and constants for the json string unescape block
// used by json_string_unescape; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NO_QUOTE    = 3'd0;
  localparam logic [2:0] ERR_UNTERM      = 3'd1;
  localparam logic [2:0] ERR_CTRL        = 3'd2;
  localparam logic [2:0] ERR_UNTERM_ESC  = 3'd3;
  localparam logic [2:0] ERR_TRUNC_U     = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX     = 3'd5;
  localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

endpackage

`default_nettype wire

/* sv/json_string_unescape.sv */
// json string unescape: decodes one json string literal, byte by byte
// single module; depends on jsu_pkg for scan modes, result kinds and error codes
//
// usage:
//   in_*  : one raw text byte per beat in in_tdata, in_tuser high marks end of input
//           (then in_tdata is ignored); starts with the opening quote
//   out_* : decoded bytes, a done marker or an error code; out_tuser is the kind,
//           out_tlast is high on the final result caused by an input beat
// an input beat is decoded in the cycle it is accepted and its results sit in a
// three-entry result register from the next cycle.
// throughput is one byte per cycle while the receiver is ready and each byte gives
// at most one result; a \u escape that expands to two or three utf-8 bytes holds
// in_tready low while the result register drains.
// a beat is taken while the last waiting result is handed over, so a stalled
// receiver holds at most one beat of results and stops the input until drained.
// reset (rst_n low, synchronous) empties the result register and returns the
// decoder to idle, awaiting an opening quote. after done or any error it is idle
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tuser,   // [0] end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [10:8] error_code, [15:11] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last
);
  import jsu_pkg::*;

  // decoder state
  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic        bad_r, bad_nxt;

  // result register, entry 0 is presented
  logic [7:0]  res0_r, res1_r, res2_r;
  logic [7:0]  res0_nxt, res1_nxt, res2_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [1:0]  rem_r, rem_nxt;

  logic        acc, pop, eoi;
  logic [7:0]  b;
  logic [3:0]  hex_d;
  logic        hex_ok;
  logic [15:0] cp_new;
  logic [7:0]  esc_d;
  logic        esc_simple;

  // decode results of the current beat
  logic [1:0]  n_res;
  logic [7:0]  d0, d1, d2;
  logic [1:0]  d_kind;
  logic [2:0]  d_err;

  assign b   = in_tdata;
  assign eoi = in_tuser;
  assign acc = in_tvalid && in_tready;
  assign pop = out_tvalid && out_tready;

  assign in_tready  = (rem_r == 2'd0) || ((rem_r == 2'd1) && out_tready);
  assign out_tvalid = (rem_r != 2'd0);
  assign out_tdata  = {5'd0, err_r, res0_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = (rem_r == 2'd1);

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_d = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_d = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_d = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_new = {cp_r[11:0], hex_d};

  always_comb begin
    esc_simple = 1'b1;
    esc_d      = 8'd0;
    case (b)
      8'h22: esc_d = 8'h22;
      8'h5C: esc_d = 8'h5C;
      8'h2F: esc_d = 8'h2F;
      8'h6E: esc_d = 8'h0A;
      8'h72: esc_d = 8'h0D;
      8'h74: esc_d = 8'h09;
      8'h62: esc_d = 8'h08;
      8'h66: esc_d = 8'h0C;
      default: esc_simple = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    bad_nxt     = bad_r;
    if (acc) begin
      case (mode_r)
        MODE_IDLE: begin
          if (!eoi && b == CH_QUOTE) mode_nxt = MODE_STR;
        end
        MODE_STR: begin
          if (eoi || b == CH_QUOTE || b < CH_SPACE) begin
            mode_nxt = MODE_IDLE;
          end else if (b == CH_BSL) begin
            mode_nxt = MODE_ESC;
          end
        end
        MODE_ESC: begin
          if (eoi) begin
            mode_nxt = MODE_IDLE;
          end else if (esc_simple) begin
            mode_nxt = MODE_STR;
          end else if (b == 8'h75) begin
            mode_nxt    = MODE_HEX;
            hex_cnt_nxt = 2'd0;
            cp_nxt      = 16'd0;
            bad_nxt     = 1'b0;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_HEX: begin
          if (eoi) begin
            mode_nxt    = MODE_IDLE;
            hex_cnt_nxt = 2'd0;
            cp_nxt      = 16'd0;
            bad_nxt     = 1'b0;
          end else if (hex_cnt_r != 2'd3) begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            cp_nxt      = cp_new;
            bad_nxt     = bad_r | ~hex_ok;
          end else begin
            // fourth digit closes the escape either way
            mode_nxt    = (bad_r | ~hex_ok) ? MODE_IDLE : MODE_STR;
            hex_cnt_nxt = 2'd0;
            cp_nxt      = 16'd0;
            bad_nxt     = 1'b0;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end
  end

  // results of the beat
  always_comb begin
    n_res  = 2'd0;
    d0     = 8'd0;
    d1     = 8'd0;
    d2     = 8'd0;
    d_kind = KIND_DATA;
    d_err  = 3'd0;
    case (mode_r)
      MODE_IDLE: begin
        if (eoi || b != CH_QUOTE) begin
          n_res  = 2'd1;
          d_kind = KIND_ERR;
          d_err  = ERR_NO_QUOTE;
        end
      end
      MODE_STR: begin
        if (eoi) begin
          n_res  = 2'd1;
          d_kind = KIND_ERR;
          d_err  = ERR_UNTERM;
        end else if (b == CH_QUOTE) begin
          n_res  = 2'd1;
          d_kind = KIND_DONE;
        end else if (b < CH_SPACE) begin
          n_res  = 2'd1;
          d_kind = KIND_ERR;
          d_err  = ERR_CTRL;
        end else if (b != CH_BSL) begin
          n_res = 2'd1;
          d0    = b;
        end
      end
      MODE_ESC: begin
        if (eoi) begin
          n_res  = 2'd1;
          d_kind = KIND_ERR;
          d_err  = ERR_UNTERM_ESC;
        end else if (esc_simple) begin
          n_res = 2'd1;
          d0    = esc_d;
        end else if (b != 8'h75) begin
          n_res  = 2'd1;
          d_kind = KIND_ERR;
          d_err  = ERR_UNKNOWN_ESC;
        end
      end
      MODE_HEX: begin
        if (eoi) begin
          n_res  = 2'd1;
          d_kind = KIND_ERR;
          d_err  = ERR_TRUNC_U;
        end else if (hex_cnt_r == 2'd3) begin
          if (bad_r || !hex_ok) begin
            n_res  = 2'd1;
            d_kind = KIND_ERR;
            d_err  = ERR_BAD_HEX;
          end else if (cp_new < 16'h0080) begin
            n_res = 2'd1;
            d0    = cp_new[7:0];
          end else if (cp_new < 16'h0800) begin
            n_res = 2'd2;
            d0    = UTF8_LEAD2 | {3'd0, cp_new[10:6]};
            d1    = UTF8_CONT | {2'd0, cp_new[5:0]};
          end else begin
            n_res = 2'd3;
            d0    = UTF8_LEAD3 | {4'd0, cp_new[15:12]};
            d1    = UTF8_CONT | {2'd0, cp_new[11:6]};
            d2    = UTF8_CONT | {2'd0, cp_new[5:0]};
          end
        end
      end
      default: n_res = 2'd0;
    endcase
  end

  // result register load and drain
  always_comb begin
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    res2_nxt = res2_r;
    kind_nxt = kind_r;
    err_nxt  = err_r;
    rem_nxt  = rem_r;
    if (acc && n_res != 2'd0) begin
      res0_nxt = d0;
      res1_nxt = d1;
      res2_nxt = d2;
      kind_nxt = d_kind;
      err_nxt  = d_err;
      rem_nxt  = n_res;
    end else if (pop) begin
      res0_nxt = res1_r;
      res1_nxt = res2_r;
      rem_nxt  = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= 2'd0;
      cp_r      <= 16'd0;
      bad_r     <= 1'b0;
      rem_r     <= 2'd0;
    end else begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
      bad_r     <= bad_nxt;
      rem_r     <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
    res2_r <= res2_nxt;
    kind_r <= kind_nxt;
    err_r  <= err_nxt;
  end

  // hex gathering state is clean outside a \u escape
  a_hex_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_HEX) |-> (hex_cnt_r == 2'd0 && !bad_r))
    else $error("hex state not cleared outside escape");

  // done and error results always stand alone
  a_single_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_DATA) |-> out_tlast)
    else $error("done or error result not marked last");

  // end of input always leaves the decoder idle
  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && eoi) |=> (mode_r == MODE_IDLE))
    else $error("decoder not idle after end of input");

  // a multi-byte burst keeps presenting until its last beat
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !out_tlast) |=> out_tvalid)
    else $error("utf-8 burst broken");

endmodule

`default_nettype wire

/* sim/tb_json_string_unescape.sv */
`timescale 1ns / 1ps
// self-checking bench for json_string_unescape: streams json string text, well formed
// and broken, and checks every decoded byte, done marker and error code beat by beat
// depends on jsu_pkg and json_string_unescape
module tb_json_string_unescape;
  import jsu_pkg::*;

  localparam logic [2:0] NO_CODE = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic [7:0] gap;
    logic       drain;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [15:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tlast;

  json_string_unescape dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  text_beat_t text_q[$];
  result_t    decoded_q[$];
  int         fail_cnt = 0;
  logic       in_taken = 1'b0;
  int         in_wait = 0;
  logic       in_quiet = 1'b0;
  logic       next_drain = 1'b0;
  int         ready_mode = 0;
  int         ready_span = 0;
  int         ready_hold = 0;

  // decoder state mirrored on the bench side
  mode_t       scan_mode_q = MODE_IDLE;
  logic [1:0]  hex_n = 2'd0;
  logic [15:0] cp_acc = 16'd0;
  logic        hex_bad = 1'b0;

  function automatic result_t word(input logic [7:0] d, input logic [1:0] k,
                                   input logic [2:0] c);
    word = '{data: d, kind: k, code: c, last: 1'b0};
  endfunction

  function automatic result_t abort(input logic [2:0] c);
    scan_mode_q = MODE_IDLE;
    hex_n = 2'd0;
    cp_acc = 16'd0;
    hex_bad = 1'b0;
    abort = word(8'd0, KIND_ERR, c);
  endfunction

  task automatic unescape_byte(input logic [7:0] b, input logic eoi);
    result_t     res [3];
    int          n;
    logic [7:0]  d;
    logic        simple;
    logic [3:0]  nib;
    logic [15:0] cp;
    n = 0;
    case (scan_mode_q)
      MODE_IDLE: begin
        if (eoi || b != CH_QUOTE) begin
          res[0] = abort(ERR_NO_QUOTE);
          n = 1;
        end else begin
          scan_mode_q = MODE_STR;
        end
      end
      MODE_STR: begin
        if (eoi) begin
          res[0] = abort(ERR_UNTERM);
          n = 1;
        end else if (b == CH_QUOTE) begin
          scan_mode_q = MODE_IDLE;
          res[0] = word(8'd0, KIND_DONE, NO_CODE);
          n = 1;
        end else if (b < CH_SPACE) begin
          res[0] = abort(ERR_CTRL);
          n = 1;
        end else if (b == CH_BSL) begin
          scan_mode_q = MODE_ESC;
        end else begin
          res[0] = word(b, KIND_DATA, NO_CODE);
          n = 1;
        end
      end
      MODE_ESC: begin
        simple = 1'b1;
        d = b;
        case (b)
          CH_QUOTE, CH_BSL, "/": d = b;
          "n": d = 8'h0A;
          "r": d = 8'h0D;
          "t": d = 8'h09;
          "b": d = 8'h08;
          "f": d = 8'h0C;
          default: simple = 1'b0;
        endcase
        if (eoi) begin
          res[0] = abort(ERR_UNTERM_ESC);
          n = 1;
        end else if (simple) begin
          scan_mode_q = MODE_STR;
          res[0] = word(d, KIND_DATA, NO_CODE);
          n = 1;
        end else if (b == "u") begin
          scan_mode_q = MODE_HEX;
          hex_n = 2'd0;
          cp_acc = 16'd0;
          hex_bad = 1'b0;
        end else begin
          res[0] = abort(ERR_UNKNOWN_ESC);
          n = 1;
        end
      end
      default: begin
        if (eoi) begin
          // truncation wins over any bad digit seen so far
          res[0] = abort(ERR_TRUNC_U);
          n = 1;
        end else begin
          if (b >= "0" && b <= "9") begin
            nib = b[3:0];
          end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            nib = b[3:0] + 4'd9;
          end else begin
            nib = 4'd0;
            hex_bad = 1'b1;
          end
          cp_acc = {cp_acc[11:0], nib};
          if (hex_n != 2'd3) begin
            hex_n = hex_n + 2'd1;
          end else if (hex_bad) begin
            res[0] = abort(ERR_BAD_HEX);
            n = 1;
          end else begin
            cp = cp_acc;
            if (cp < 16'h0080) begin
              res[0] = word(cp[7:0], KIND_DATA, NO_CODE);
              n = 1;
            end else if (cp < 16'h0800) begin
              res[0] = word(UTF8_LEAD2 | {3'd0, cp[10:6]}, KIND_DATA, NO_CODE);
              res[1] = word(UTF8_CONT | {2'd0, cp[5:0]}, KIND_DATA, NO_CODE);
              n = 2;
            end else begin
              res[0] = word(UTF8_LEAD3 | {4'd0, cp[15:12]}, KIND_DATA, NO_CODE);
              res[1] = word(UTF8_CONT | {2'd0, cp[11:6]}, KIND_DATA, NO_CODE);
              res[2] = word(UTF8_CONT | {2'd0, cp[5:0]}, KIND_DATA, NO_CODE);
              n = 3;
            end
            scan_mode_q = MODE_STR;
            hex_n = 2'd0;
            cp_acc = 16'd0;
            hex_bad = 1'b0;
          end
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      decoded_q.insert(decoded_q.size(), res[i]);
    end
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic logic [7:0] pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 60) pick_gap = 8'd0;
    else if (r < 90) pick_gap = 8'($urandom_range(1, 3));
    else pick_gap = 8'($urandom_range(4, 25));
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic eoi);
    text_beat_t beat;
    beat = '{b: b, eoi: eoi, gap: pick_gap(), drain: next_drain};
    text_q.insert(text_q.size(), beat);
    next_drain = 1'b0;
  endtask

  // in_tdata carries junk on an end beat, it must be ignored
  task automatic push_end();
    push_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSL);
    plain_char = c;
  endfunction

  function automatic logic escape_known(input logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSL, "/", "n", "r", "t", "b", "f", "u": escape_known = 1'b1;
      default: escape_known = 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] simple_escape();
    case ($urandom_range(0, 7))
      0: simple_escape = CH_QUOTE;
      1: simple_escape = CH_BSL;
      2: simple_escape = "/";
      3: simple_escape = "n";
      4: simple_escape = "r";
      5: simple_escape = "t";
      6: simple_escape = "b";
      default: simple_escape = "f";
    endcase
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
    non_hex = c;
  endfunction

  function automatic logic [15:0] random_cp();
    case ($urandom_range(0, 2))
      0: random_cp = 16'($urandom_range(0, 16'h007F));
      1: random_cp = 16'($urandom_range(16'h0080, 16'h07FF));
      default: random_cp = 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
  endfunction

  // first count digits of cp, msb first; the digit at bad_pos becomes a non-hex byte
  task automatic push_hex(input logic [15:0] cp, input int count, input int bad_pos);
    logic [3:0] v;
    for (int i = 0; i < count; i++) begin
      v = cp[15 - 4 * i -: 4];
      if (i == bad_pos) push_beat(non_hex(), 1'b0);
      else if (v < 4'd10) push_beat(8'("0") + 8'(v), 1'b0);
      else push_beat(($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(v) - 8'd10, 1'b0);
    end
  endtask

  task automatic push_string();
    int r;
    int len;
    logic [7:0] c;
    push_beat(CH_QUOTE, 1'b0);
    len = $urandom_range(0, 12);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_beat(plain_char(), 1'b0);
      end else if (r < 78) begin
        push_beat(CH_BSL, 1'b0);
        push_beat(simple_escape(), 1'b0);
      end else begin
        push_beat(CH_BSL, 1'b0);
        push_beat("u", 1'b0);
        push_hex(random_cp(), 4, -1);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      push_beat(CH_QUOTE, 1'b0);
    end else if (r < 76) begin
      push_end();
    end else if (r < 82) begin
      push_beat(8'($urandom_range(0, 31)), 1'b0);
    end else if (r < 88) begin
      do c = 8'($urandom_range(0, 255)); while (escape_known(c));
      push_beat(CH_BSL, 1'b0);
      push_beat(c, 1'b0);
    end else if (r < 91) begin
      push_beat(CH_BSL, 1'b0);
      push_end();
    end else if (r < 95) begin
      push_beat(CH_BSL, 1'b0);
      push_beat("u", 1'b0);
      push_hex(random_cp(), $urandom_range(0, 3), $urandom_range(0, 4));
      push_end();
    end else begin
      push_beat(CH_BSL, 1'b0);
      push_beat("u", 1'b0);
      push_hex(random_cp(), 4, $urandom_range(0, 3));
    end
  endtask

  // ---------------- input driver ----------------

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      unescape_byte(in_tdata, in_tuser);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_text
    text_beat_t nb;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (in_wait > 0) begin
        in_tvalid <= 1'b0;
        in_wait = in_wait - 1;
      end else if (text_q.size() != 0 && !(text_q[0].drain && decoded_q.size() != 0)) begin
        nb = text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nb.b;
        in_tuser  <= nb.eoi;
        in_wait = nb.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- result side ----------------

  // stall profile is redrawn when its random span runs out: none, light, heavy
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_span == 0) begin
        ready_mode = $urandom_range(0, 2);
        ready_span = $urandom_range(20, 120);
      end else begin
        ready_span = ready_span - 1;
      end
      if (ready_hold > 0) begin
        out_tready <= 1'b0;
        ready_hold = ready_hold - 1;
      end else if (ready_mode != 0 && $urandom_range(0, 99) < 20 * ready_mode) begin
        out_tready <= 1'b0;
        ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 30)
                                                 : $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_out
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        fail_cnt = fail_cnt + 1;
        if (fail_cnt <= 20)
          $display("%0t: unexpected beat byte=%h code=%0d kind=%0d last=%b", $time,
                   out_tdata[7:0], out_tdata[10:8], out_tuser, out_tlast);
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata[7:0] !== want.data || out_tdata[10:8] !== want.code ||
            out_tdata[15:11] !== 5'd0 || out_tuser !== want.kind ||
            out_tlast !== want.last) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 20)
            $display("%0t: mismatch expected byte=%h code=%0d kind=%0d last=%b pad=0, got byte=%h code=%0d kind=%0d last=%b pad=%h",
                     $time, want.data, want.code, want.kind, want.last,
                     out_tdata[7:0], out_tdata[10:8], out_tuser, out_tlast,
                     out_tdata[15:11]);
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    // idle errors: stray byte and end of input before any quote
    push_beat("A", 1'b0);
    push_end();
    // code point zero decodes to a data byte 0
    push_beat(CH_QUOTE, 1'b0);
    push_beat(CH_BSL, 1'b0);
    push_beat("u", 1'b0);
    push_hex(16'h0000, 4, -1);
    // bad digit held until the fourth hex digit of the escape
    push_beat(CH_BSL, 1'b0);
    push_beat("u", 1'b0);
    push_hex(16'h012F, 4, 0);
    // bad digit then end of input reports truncation
    push_beat(CH_QUOTE, 1'b0);
    push_beat(CH_BSL, 1'b0);
    push_beat("u", 1'b0);
    push_beat("g", 1'b0);
    push_end();
    push_beat(CH_QUOTE, 1'b0);
    push_beat(8'h1F, 1'b0);
    push_beat(CH_QUOTE, 1'b0);
    push_end();
    push_beat(CH_QUOTE, 1'b0);
    push_beat(CH_BSL, 1'b0);
    push_end();
    push_beat(CH_QUOTE, 1'b0);
    push_beat(CH_BSL, 1'b0);
    push_beat("z", 1'b0);

    // random part; the first beat waits for the directed results to drain
    next_drain = 1'b1;
    while (text_q.size() < 360) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) next_drain = 1'b1;
      if ($urandom_range(0, 99) < 85) push_string();
      else if ($urandom_range(0, 1) == 0) push_beat(8'($urandom_range(0, 255)), 1'b0);
      else push_end();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_tvalid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/jsu_pkg.sv
sv/json_string_unescape.sv
sim/tb_json_string_unescape.sv
